// ----- rtl/core/far_pkg.sv -----
`timescale 1ns / 1ps

package far_pkg;

  // Replacement policy codes, as written through the configuration port.
  typedef enum logic [1:0] {
    POL_RANDOM = 2'd0,
    POL_FIFO   = 2'd1,
    POL_LFU    = 2'd2,
    POL_LRU    = 2'd3
  } policy_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES  = 1'd1;

  // Fixed field widths of the stream words.
  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned PICK_W  = 4;
  localparam int unsigned LINE_W  = 4;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 24;

  // Use counters saturate at all ones.
  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Flags of the search record that walks down the row of cells.
  typedef struct packed {
    logic tok;    // record is live in this stage
    logic hit;    // a matching line was found
    logic empty;  // an empty line in use was found
    logic vic;    // a victim candidate is held
  } srch_flags_t;

  // Update command broadcast to every cell at the end of an access.
  typedef struct packed {
    logic en;       // apply this command
    logic fill;     // write tag into the selected line, count restarts at one
    logic bump;     // raise the selected line's use count
    logic age;      // make the selected line newest
    logic age_all;  // selected line was empty: every other valid line ages
  } upd_t;

endpackage

// ----- rtl/core/far_cell.sv -----
`timescale 1ns / 1ps

module far_cell #(
  parameter int unsigned LINES      = 16,
  parameter int unsigned BLOCK_BITS = 16,
  parameter int unsigned IDX        = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(LINES+1)-1:0]      n_i,
  input  far_pkg::policy_e                policy_i,
  input  logic [$clog2(LINES)-1:0]        rnd_idx_i,
  input  logic [BLOCK_BITS-1:0]           blk_i,
  input  far_pkg::srch_flags_t            flags_i,
  input  logic [$clog2(LINES)-1:0]        h_idx_i,
  input  logic [$clog2(LINES)-1:0]        h_rank_i,
  input  logic [$clog2(LINES)-1:0]        e_idx_i,
  input  logic [$clog2(LINES)-1:0]        v_idx_i,
  input  logic [BLOCK_BITS-1:0]           v_tag_i,
  input  logic [far_pkg::CNT_W-1:0]       v_cnt_i,
  input  logic [$clog2(LINES)-1:0]        v_rank_i,
  output far_pkg::srch_flags_t            flags_o,
  output logic [$clog2(LINES)-1:0]        h_idx_o,
  output logic [$clog2(LINES)-1:0]        h_rank_o,
  output logic [$clog2(LINES)-1:0]        e_idx_o,
  output logic [$clog2(LINES)-1:0]        v_idx_o,
  output logic [BLOCK_BITS-1:0]           v_tag_o,
  output logic [far_pkg::CNT_W-1:0]       v_cnt_o,
  output logic [$clog2(LINES)-1:0]        v_rank_o,
  input  far_pkg::upd_t                   upd_i,
  input  logic [$clog2(LINES)-1:0]        upd_sel_i,
  input  logic [$clog2(LINES)-1:0]        upd_old_i
);
  import far_pkg::*;

  localparam int unsigned LW = $clog2(LINES);
  localparam int unsigned NW = $clog2(LINES + 1);
  localparam int unsigned TW = BLOCK_BITS;

  // Line state held by this cell.
  logic [TW-1:0]    tag_q;
  logic             valid_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LW-1:0]    rank_q;

  // Search record, next and registered.
  srch_flags_t      flags_d, flags_q;
  logic [LW-1:0]    h_idx_d, h_idx_q;
  logic [LW-1:0]    h_rank_d, h_rank_q;
  logic [LW-1:0]    e_idx_d, e_idx_q;
  logic [LW-1:0]    v_idx_d, v_idx_q;
  logic [TW-1:0]    v_tag_d, v_tag_q;
  logic [CNT_W-1:0] v_cnt_d, v_cnt_q;
  logic [LW-1:0]    v_rank_d, v_rank_q;

  logic act;
  logic take;
  logic is_sel;

  always_comb begin
    act      = NW'(IDX) < n_i;
    flags_d  = flags_i;
    h_idx_d  = h_idx_i;
    h_rank_d = h_rank_i;
    e_idx_d  = e_idx_i;
    v_idx_d  = v_idx_i;
    v_tag_d  = v_tag_i;
    v_cnt_d  = v_cnt_i;
    v_rank_d = v_rank_i;

    if (act && valid_q && (tag_q == blk_i) && !flags_i.hit) begin
      flags_d.hit = 1'b1;
      h_idx_d     = LW'(IDX);
      h_rank_d    = rank_q;
    end

    if (act && !valid_q && !flags_i.empty) begin
      flags_d.empty = 1'b1;
      e_idx_d       = LW'(IDX);
    end

    unique case (policy_i)
      POL_RANDOM: take = act && (rnd_idx_i == LW'(IDX));
      POL_LFU: take = act && (!flags_i.vic || (cnt_q < v_cnt_i) ||
                              ((cnt_q == v_cnt_i) && (tag_q < v_tag_i)));
      POL_FIFO, POL_LRU: take = act && (!flags_i.vic || (rank_q > v_rank_i));
      default: take = 1'b0;
    endcase

    if (take) begin
      flags_d.vic = 1'b1;
      v_idx_d     = LW'(IDX);
      v_tag_d     = tag_q;
      v_cnt_d     = cnt_q;
      v_rank_d    = rank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (flags_i.tok) begin
      flags_q <= flags_d;
    end else begin
      flags_q.tok <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flags_i.tok) begin
      h_idx_q  <= h_idx_d;
      h_rank_q <= h_rank_d;
      e_idx_q  <= e_idx_d;
      v_idx_q  <= v_idx_d;
      v_tag_q  <= v_tag_d;
      v_cnt_q  <= v_cnt_d;
      v_rank_q <= v_rank_d;
    end
  end

  assign flags_o  = flags_q;
  assign h_idx_o  = h_idx_q;
  assign h_rank_o = h_rank_q;
  assign e_idx_o  = e_idx_q;
  assign v_idx_o  = v_idx_q;
  assign v_tag_o  = v_tag_q;
  assign v_cnt_o  = v_cnt_q;
  assign v_rank_o = v_rank_q;

  // Line state update from the broadcast command.
  assign is_sel = upd_sel_i == LW'(IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      rank_q  <= '0;
    end else if (upd_i.en) begin
      if (is_sel) begin
        // A saturated count on a hit simply stays where it is.
        if (upd_i.fill) begin
          valid_q <= 1'b1;
          cnt_q   <= CNT_W'(1);
        end else if (upd_i.bump && (cnt_q != CNT_MAX)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (upd_i.age) begin
          rank_q <= '0;
        end
      end else if (upd_i.age && valid_q && (upd_i.age_all || (rank_q < upd_old_i))) begin
        rank_q <= rank_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && is_sel && upd_i.fill) begin
      tag_q <= blk_i;
    end
  end

endmodule

// ----- rtl/core/fully_associative_cache_replacement_top.sv -----
`timescale 1ns / 1ps

// Tag-only fully associative cache with selectable replacement policy.
// Each word on the slave stream is one access: a block number and a random
// value used only by the random policy. Each access returns exactly one word
// on the master stream: hit flag, line used, and the evicted block if a valid
// block was replaced. The configuration channel writes the policy (index 0)
// and the number of lines in use (index 1); write it only while idle.
// The search record walks the row of line cells one cell per cycle,
// collecting hit, first empty line and victim candidate on its way; a new
// word is taken only after the previous access has been resolved.
// Reset empties every line, clears use counts and ages, selects the random
// policy and puts all built lines in use.
// When the receiver stalls, the finished result waits in front of the output
// register; the line state is updated only when the result is loaded, and no
// new word is taken until then.
module fully_associative_cache_replacement_top #(
  parameter int unsigned LINES      = 16,
  parameter int unsigned BLOCK_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: block [15:0], random_pick [19:16], zero [23:20]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [far_pkg::IN_W-1:0]           s_axis_tdata,
  // tdata: hit [0], line [4:1], evicted_valid [5], evicted_block [21:6], zero [23:22]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [far_pkg::OUT_W-1:0]          m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [far_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [far_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import far_pkg::*;

  localparam int unsigned LW    = $clog2(LINES);
  localparam int unsigned NW    = $clog2(LINES + 1);
  localparam int unsigned TW    = BLOCK_BITS;
  localparam int unsigned LIU_W = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  policy_e          policy_q;
  logic [LIU_W-1:0] liu_q;
  logic [NW-1:0]    n_lines;

  // Current access.
  logic [TW-1:0]     blk_q;
  logic [PICK_W-1:0] pick_q;
  logic              tok_q;
  logic [LW-1:0]     rnd_idx;
  logic              s_acc;

  // Output register.
  logic              m_valid_q;
  logic              hit_q;
  logic [LINE_W-1:0] line_q;
  logic              evv_q;
  logic [BLOCK_W-1:0] evb_q;
  logic              out_free;

  // Record boundaries along the row; boundary i feeds cell i.
  srch_flags_t      flg_w    [LINES+1];
  logic [LW-1:0]    hidx_w   [LINES+1];
  logic [LW-1:0]    hrank_w  [LINES+1];
  logic [LW-1:0]    eidx_w   [LINES+1];
  logic [LW-1:0]    vidx_w   [LINES+1];
  logic [TW-1:0]    vtag_w   [LINES+1];
  logic [CNT_W-1:0] vcnt_w   [LINES+1];
  logic [LW-1:0]    vrank_w  [LINES+1];

  // Resolution of the finished record.
  srch_flags_t  fin;
  logic         do_finish;
  logic [LW-1:0] sel;
  logic [LW-1:0] old_rank;
  logic         ev_valid;
  upd_t         upd;

  // Remainder of a 4-bit value by the line count, restoring one quotient
  // bit per step.
  function automatic logic [LW-1:0] pick_mod(input logic [PICK_W-1:0] p,
                                             input logic [NW-1:0] d);
    logic [NW+PICK_W-1:0] rem;
    logic [NW+PICK_W-1:0] dv;
    rem = (NW + PICK_W)'(p);
    for (int k = PICK_W - 1; k >= 0; k--) begin
      dv = (NW + PICK_W)'(d) << k;
      if (rem >= dv) begin
        rem = rem - dv;
      end
    end
    return LW'(rem);
  endfunction

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_RANDOM;
      liu_q    <= LIU_W'(LINES);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_POLICY) begin
        policy_q <= policy_e'(cfg_data_i[1:0]);
      end else if (cfg_index_i == CFG_LINES) begin
        liu_q <= LIU_W'(cfg_data_i);
      end
    end
  end

  // A count of zero works as one line; more than built works as all lines.
  always_comb begin
    if (liu_q == '0) begin
      n_lines = NW'(1);
    end else if (liu_q > LIU_W'(LINES)) begin
      n_lines = NW'(LINES);
    end else begin
      n_lines = NW'(liu_q);
    end
  end

  assign rnd_idx = pick_mod(pick_q, n_lines);

  // Input side: one access at a time.
  assign s_axis_tready = state_q == ST_IDLE;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      blk_q  <= TW'(s_axis_tdata[BLOCK_W-1:0]);
      pick_q <= s_axis_tdata[BLOCK_W+PICK_W-1:BLOCK_W];
    end
  end

  // The record enters the row empty, carrying only the token.
  assign flg_w[0]   = '{tok: tok_q, hit: 1'b0, empty: 1'b0, vic: 1'b0};
  assign hidx_w[0]  = '0;
  assign hrank_w[0] = '0;
  assign eidx_w[0]  = '0;
  assign vidx_w[0]  = '0;
  assign vtag_w[0]  = '0;
  assign vcnt_w[0]  = '0;
  assign vrank_w[0] = '0;

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    far_cell #(
      .LINES      (LINES),
      .BLOCK_BITS (BLOCK_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .n_i       (n_lines),
      .policy_i  (policy_q),
      .rnd_idx_i (rnd_idx),
      .blk_i     (blk_q),
      .flags_i   (flg_w[g]),
      .h_idx_i   (hidx_w[g]),
      .h_rank_i  (hrank_w[g]),
      .e_idx_i   (eidx_w[g]),
      .v_idx_i   (vidx_w[g]),
      .v_tag_i   (vtag_w[g]),
      .v_cnt_i   (vcnt_w[g]),
      .v_rank_i  (vrank_w[g]),
      .flags_o   (flg_w[g+1]),
      .h_idx_o   (hidx_w[g+1]),
      .h_rank_o  (hrank_w[g+1]),
      .e_idx_o   (eidx_w[g+1]),
      .v_idx_o   (vidx_w[g+1]),
      .v_tag_o   (vtag_w[g+1]),
      .v_cnt_o   (vcnt_w[g+1]),
      .v_rank_o  (vrank_w[g+1]),
      .upd_i     (upd),
      .upd_sel_i (sel),
      .upd_old_i (old_rank)
    );
  end

  // The last cell keeps its record until the next token passes, so a stalled
  // result can be resolved from it later.
  assign fin      = flg_w[LINES];
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    do_finish = ((state_q == ST_SEARCH && fin.tok) || state_q == ST_HOLD) && out_free;

    priority if (fin.hit) begin
      sel = hidx_w[LINES];
    end else if (fin.empty) begin
      sel = eidx_w[LINES];
    end else begin
      sel = vidx_w[LINES];
    end
    old_rank = fin.hit ? hrank_w[LINES] : vrank_w[LINES];
    ev_valid = !fin.hit && !fin.empty;

    // A hit ages only under LRU; every miss makes its line newest.
    upd.en      = do_finish;
    upd.fill    = !fin.hit;
    upd.bump    = fin.hit;
    upd.age     = !fin.hit || (policy_q == POL_LRU);
    upd.age_all = !fin.hit && fin.empty;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (fin.tok) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (do_finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_finish) begin
      hit_q  <= fin.hit;
      line_q <= LINE_W'(sel);
      evv_q  <= ev_valid;
      evb_q  <= ev_valid ? BLOCK_W'(vtag_w[LINES]) : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_W - BLOCK_W - LINE_W - 2)'(0), evb_q, evv_q, line_q, hit_q};

  // The record reaches the end of the row only while a search is running.
  a_tok_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.tok |-> state_q == ST_SEARCH)
    else $error("search record left the row outside a search");

  // Only one access is in flight.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("second word taken while an access is in flight");

  // Every line update is paired with a result word.
  a_update_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.en |=> m_axis_tvalid)
    else $error("line state updated without a result word");

endmodule

// ----- sim/fully_associative_cache_replacement_top_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the tag-only fully associative cache.
module fully_associative_cache_replacement_top_tb;
  import far_pkg::*;

  localparam int unsigned LINES     = 16;
  localparam int unsigned LATENCY   = LINES + 2;
  localparam int unsigned LIMIT     = 500000;
  localparam int unsigned PHASES    = 20;
  localparam int unsigned PER_PHASE = 97;
  localparam int unsigned HOLD_PHASE  = 5;
  localparam int unsigned PAUSE_PHASE = 9;
  localparam int unsigned N_DIRECTED  = 28;

  // Same layout as the result word, hit in bit 0.
  typedef struct packed {
    logic [BLOCK_W-1:0] ev_block;
    logic               ev_valid;
    logic [LINE_W-1:0]  line;
    logic               hit;
  } access_result_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    int unsigned          value;
    logic [BLOCK_W-1:0]   blk;
    logic [PICK_W-1:0]    pick;
    bit                   typed;
    access_result_t       want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fully_associative_cache_replacement_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the cache: tags, valid bits, use counts and age order.
  logic [BLOCK_W-1:0] tag_q   [LINES];
  bit                 valid_q [LINES];
  int unsigned        uses_q  [LINES];
  int unsigned        rank_q  [LINES];
  policy_e            pol_q;
  int unsigned        lines_q;

  access_result_t expected_results [$];
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;

  // Shared between the sender and the receiver processes.
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_hold_len = 0;

  // Lines in use per random phase; zero and values above the built count
  // are legal writes and get clamped by the block.
  int unsigned lines_plan [PHASES] = '{1, 16, 0, 2, 31, 17, 3, 16, 8, 5,
                                       16, 12, 4, 1, 7, 16, 2, 10, 6, 16};

  // Directed rows. Expected words are typed in where they are obvious.
  //   kind, register, value, block, pick, typed, {ev_block, ev_valid, line, hit}
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0000, 4'd0,  1'b1, {16'h0000, 1'b0, 4'd0, 1'b0}},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'hFFFF, 4'd15, 1'b1, {16'h0000, 1'b0, 4'd1, 1'b0}},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0000, 4'd0,  1'b1, {16'h0000, 1'b0, 4'd0, 1'b1}},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'hFFFF, 4'd0,  1'b1, {16'h0000, 1'b0, 4'd1, 1'b1}},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h00AA, 4'd3,  1'b1, {16'h0000, 1'b0, 4'd2, 1'b0}},
    '{ROW_WRITE,  CFG_LINES,  2, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h1234, 4'd15, 1'b1, {16'hFFFF, 1'b1, 4'd1, 1'b0}},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h00AA, 4'd0,  1'b1, {16'h0000, 1'b1, 4'd0, 1'b0}},
    '{ROW_WRITE,  CFG_LINES,  31, 16'h0000, 4'd0, 1'b0, '0},
    // Block 00AA now sits in lines 0 and 2; the lower one must answer.
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h00AA, 4'd0,  1'b1, {16'h0000, 1'b0, 4'd0, 1'b1}},
    '{ROW_WRITE,  CFG_POLICY, POL_FIFO, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_WRITE,  CFG_LINES,  3, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h8000, 4'd7,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0001, 4'd1,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h00AA, 4'd2,  1'b0, '0},
    '{ROW_WRITE,  CFG_POLICY, POL_LFU, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0002, 4'd4,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0003, 4'd5,  1'b0, '0},
    '{ROW_WRITE,  CFG_POLICY, POL_LRU, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h8000, 4'd8,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0004, 4'd9,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h0005, 4'd10, 1'b0, '0},
    '{ROW_WRITE,  CFG_LINES,  0, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h7FFF, 4'd15, 1'b0, '0},
    '{ROW_ACCESS, CFG_POLICY, 0, 16'h7FFF, 4'd15, 1'b0, '0},
    '{ROW_WRITE,  CFG_POLICY, POL_RANDOM, 16'h0000, 4'd0, 1'b0, '0},
    // One line in use: any pick lands on line 0.
    '{ROW_ACCESS, CFG_POLICY, 0, 16'hAAAA, 4'd15, 1'b1, {16'h7FFF, 1'b1, 4'd0, 1'b0}},
    '{ROW_WRITE,  CFG_LINES,  16, 16'h0000, 4'd0, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("fully_associative_cache_replacement_top_tb: done, errors");
      $finish;
    end
  end

  // Moves line x to the front of the age order. An empty line passes LINES
  // as its old rank so that every valid line ages by one.
  function automatic void promote_line(input int unsigned x, input int unsigned old);
    for (int unsigned i = 0; i < LINES; i++) begin
      if (i != x && valid_q[i] && rank_q[i] < old) rank_q[i]++;
    end
    rank_q[x] = 0;
  endfunction

  function automatic access_result_t cache_access(input logic [BLOCK_W-1:0] blk,
                                                  input logic [PICK_W-1:0] pick);
    access_result_t r;
    int unsigned    n;
    int unsigned    sel;
    bit             found;
    bit             empty;
    r     = '0;
    sel   = 0;
    found = 1'b0;
    empty = 1'b0;
    n = (lines_q < 1) ? 1 : (lines_q > LINES) ? LINES : lines_q;
    for (int unsigned i = 0; i < n && !found; i++) begin
      if (valid_q[i] && tag_q[i] == blk) begin
        found = 1'b1;
        sel   = i;
      end
    end
    if (found) begin
      if (uses_q[sel] < CNT_MAX) uses_q[sel]++;
      if (pol_q == POL_LRU) promote_line(sel, rank_q[sel]);
      r.hit  = 1'b1;
      r.line = sel[LINE_W-1:0];
      return r;
    end
    for (int unsigned i = 0; i < n && !empty; i++) begin
      if (!valid_q[i]) begin
        empty = 1'b1;
        sel   = i;
      end
    end
    if (empty) begin
      promote_line(sel, LINES);
    end else begin
      case (pol_q)
        POL_RANDOM: sel = pick % n;
        POL_LFU: begin
          sel = 0;
          for (int unsigned i = 1; i < n; i++) begin
            if (uses_q[i] < uses_q[sel] ||
                (uses_q[i] == uses_q[sel] && tag_q[i] < tag_q[sel])) sel = i;
          end
        end
        default: begin
          // FIFO and LRU both take the oldest line, lowest index on a tie.
          sel = 0;
          for (int unsigned i = 1; i < n; i++) begin
            if (rank_q[i] > rank_q[sel]) sel = i;
          end
        end
      endcase
      r.ev_valid = 1'b1;
      r.ev_block = tag_q[sel];
      promote_line(sel, rank_q[sel]);
    end
    tag_q[sel]   = blk;
    valid_q[sel] = 1'b1;
    uses_q[sel]  = 1;
    r.line = sel[LINE_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_access(input logic [BLOCK_W-1:0] blk, input logic [PICK_W-1:0] pick,
                             input bit typed, input access_result_t typed_res);
    int unsigned    gap;
    access_result_t pred;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - BLOCK_W - PICK_W){1'b0}}, pick, blk};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = cache_access(blk, pick);
    expected_results.push_back(typed ? typed_res : pred);
  endtask

  // Drops valid and waits until every expected word is back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_POLICY) pol_q = policy_e'(value[1:0]);
    else lines_q = value & 31;
    @(posedge clk_i);
  endtask

  // Result checker: every accepted word is matched against the oldest
  // expectation.
  always @(posedge clk_i) begin
    access_result_t got;
    access_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = access_result_t'(m_axis_tdata[$bits(access_result_t)-1:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("line", want.line, got.line);
        check_field("evicted_valid", want.ev_valid, got.ev_valid);
        check_field("evicted_block", want.ev_block, got.ev_block);
      end
    end
  end

  // Receiver: random back-pressure per word, plus one long hold on request.
  initial begin
    int unsigned pause;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        pause = rx_hold_len;
        rx_hold_len = 0;
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      pause = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [BLOCK_W-1:0] pool [20];
    logic [BLOCK_W-1:0] blk;
    int unsigned        n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_POLICY;
    cfg_data_i    = '0;
    for (int unsigned i = 0; i < LINES; i++) begin
      tag_q[i]   = '0;
      valid_q[i] = 1'b0;
      uses_q[i]  = 0;
      rank_q[i]  = 0;
    end
    pol_q   = POL_RANDOM;
    lines_q = LINES;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset state, extreme blocks, duplicate tags, every
    // policy and the clamped line counts.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        send_access(directed_rows[r].blk, directed_rows[r].pick,
                    directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random phases. Most blocks come from a small working set a little
    // larger than the lines in use, so hits and evictions both happen often.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_POLICY, ph % 4);
      write_reg(CFG_LINES, lines_plan[ph]);
      n = (lines_plan[ph] < 1) ? 1 : (lines_plan[ph] > LINES) ? LINES : lines_plan[ph];
      for (int unsigned i = 0; i < n + 3; i++) pool[i] = BLOCK_W'($urandom_range(0, 65535));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) begin
        // Back-to-back words against a receiver that stops for a long time.
        tx_idle_on  = 1'b0;
        rx_hold_len = 300;
      end
      for (int unsigned k = 0; k < PER_PHASE; k++) begin
        if (ph == PAUSE_PHASE && k == PER_PHASE / 2) wait_idle();
        if ($urandom_range(0, 4) == 0) blk = BLOCK_W'($urandom_range(0, 65535));
        else blk = pool[$urandom_range(0, n + 2)];
        send_access(blk, PICK_W'($urandom_range(0, 15)), 1'b0, '0);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("fully_associative_cache_replacement_top_tb: done, clean");
    end else begin
      $display("fully_associative_cache_replacement_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/far_pkg.sv
rtl/core/far_cell.sv
rtl/core/fully_associative_cache_replacement_top.sv
sim/fully_associative_cache_replacement_top_tb.sv
